@@ sv/lcmd_pkg.sv @@
// shared types, codes and marker constants for the length checked message deframer
package lcmd_pkg;

  // operation codes of an input transaction
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // parser phases
  localparam logic [2:0] PH_OPEN    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_HMARK   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_TMARK   = 3'd4;
  localparam logic [2:0] PH_LEN2    = 3'd5;
  localparam logic [2:0] PH_CLOSE   = 3'd6;

  // four byte markers, first byte in the lowest lane
  localparam logic [31:0] MARK_OPEN  = 32'h5B4D4454;
  localparam logic [31:0] MARK_HDR   = 32'h2020205D;
  localparam logic [31:0] MARK_TRL   = 32'h28202020;
  localparam logic [31:0] MARK_CLOSE = 32'h4D445429;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
  } result_t;

  // result handed from the parser to the output stage
  typedef struct packed {
    logic    valid;
    result_t data;
  } result_slot_t;

  function automatic logic [7:0] lane(input logic [31:0] word, input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0: b = word[7:0];
      2'd1: b = word[15:8];
      2'd2: b = word[23:16];
      2'd3: b = word[31:24];
      default: b = word[7:0];
    endcase
    return b;
  endfunction

endpackage

@@ sv/lcmd_in_stage.sv @@
// input register holding one accepted transaction until the parser takes it
module lcmd_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  lcmd_pkg::item_t item,
  input  logic            advance,
  output logic            held_valid,
  output lcmd_pkg::item_t held_item
);

  logic accept;

  assign item_stall = held_valid && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item <= item;
    end
  end

endmodule

@@ sv/lcmd_parser.sv @@
// frame parser state and the per byte check logic
module lcmd_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  lcmd_pkg::item_t        item,
  output lcmd_pkg::result_slot_t res
);

  logic [2:0]  phase, phase_next;
  logic [1:0]  field_byte_index, field_byte_index_next;
  logic [31:0] frame_length, frame_length_next;
  logic [30:0] payload_remaining, payload_remaining_next;
  logic        halted, halted_next;

  logic        field_last;
  logic [1:0]  idx_adv;
  logic [7:0]  b;
  logic [30:0] rem_dec;

  assign b          = item.rx_byte;
  assign field_last = (field_byte_index == 2'd3);
  assign idx_adv    = field_byte_index + 2'd1;
  assign rem_dec    = payload_remaining - 31'd1;

  always_comb begin
    phase_next             = phase;
    field_byte_index_next  = field_byte_index;
    frame_length_next      = frame_length;
    payload_remaining_next = payload_remaining;
    halted_next            = halted;
    res                    = '0;
    if (fire) begin
      if (item.operation == lcmd_pkg::OP_RESTART) begin
        phase_next             = lcmd_pkg::PH_OPEN;
        field_byte_index_next  = 2'd0;
        frame_length_next      = '0;
        payload_remaining_next = '0;
        halted_next            = 1'b0;
      end else if (!halted) begin
        unique case (phase)
          lcmd_pkg::PH_OPEN: begin
            if (b != lcmd_pkg::lane(lcmd_pkg::MARK_OPEN, field_byte_index)) begin
              halted_next = 1'b1;
            end else begin
              field_byte_index_next = idx_adv;
              if (field_last) phase_next = lcmd_pkg::PH_LEN;
            end
          end
          lcmd_pkg::PH_LEN: begin
            unique case (field_byte_index)
              2'd0: frame_length_next[7:0]   = b;
              2'd1: frame_length_next[15:8]  = b;
              2'd2: frame_length_next[23:16] = b;
              2'd3: frame_length_next[31:24] = b;
              default: frame_length_next[7:0] = b;
            endcase
            field_byte_index_next = idx_adv;
            if (field_last) begin
              if (b[7]) begin
                halted_next = 1'b1;
              end else begin
                payload_remaining_next = frame_length_next[30:0];
                phase_next             = lcmd_pkg::PH_HMARK;
              end
            end
          end
          lcmd_pkg::PH_HMARK: begin
            if (b != lcmd_pkg::lane(lcmd_pkg::MARK_HDR, field_byte_index)) begin
              halted_next = 1'b1;
            end else begin
              field_byte_index_next = idx_adv;
              if (field_last) begin
                phase_next = (payload_remaining == '0) ? lcmd_pkg::PH_TMARK
                                                       : lcmd_pkg::PH_PAYLOAD;
              end
            end
          end
          lcmd_pkg::PH_PAYLOAD: begin
            payload_remaining_next = rem_dec;
            if (rem_dec == '0) phase_next = lcmd_pkg::PH_TMARK;
            res.valid             = 1'b1;
            res.data.kind         = lcmd_pkg::KIND_PAYLOAD;
            res.data.payload_byte = b;
          end
          lcmd_pkg::PH_TMARK: begin
            if (b != lcmd_pkg::lane(lcmd_pkg::MARK_TRL, field_byte_index)) begin
              halted_next = 1'b1;
            end else begin
              field_byte_index_next = idx_adv;
              if (field_last) phase_next = lcmd_pkg::PH_LEN2;
            end
          end
          lcmd_pkg::PH_LEN2: begin
            if (b != lcmd_pkg::lane(frame_length, field_byte_index)) begin
              halted_next = 1'b1;
            end else begin
              field_byte_index_next = idx_adv;
              if (field_last) phase_next = lcmd_pkg::PH_CLOSE;
            end
          end
          lcmd_pkg::PH_CLOSE: begin
            if (b != lcmd_pkg::lane(lcmd_pkg::MARK_CLOSE, field_byte_index)) begin
              halted_next = 1'b1;
            end else begin
              field_byte_index_next = idx_adv;
              if (field_last) begin
                phase_next             = lcmd_pkg::PH_OPEN;
                frame_length_next      = '0;
                payload_remaining_next = '0;
                res.valid              = 1'b1;
                res.data.kind          = lcmd_pkg::KIND_DONE;
              end
            end
          end
          default: begin
            halted_next = 1'b1;
          end
        endcase
        if (halted_next) begin
          res.valid     = 1'b1;
          res.data.kind = lcmd_pkg::KIND_ERROR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lcmd_pkg::PH_OPEN;
      field_byte_index  <= 2'd0;
      frame_length      <= '0;
      payload_remaining <= '0;
      halted            <= 1'b0;
    end else begin
      phase             <= phase_next;
      field_byte_index  <= field_byte_index_next;
      frame_length      <= frame_length_next;
      payload_remaining <= payload_remaining_next;
      halted            <= halted_next;
    end
  end

endmodule

@@ sv/lcmd_out_stage.sv @@
// result register towards the downstream channel
module lcmd_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  lcmd_pkg::result_slot_t res,
  output logic                   free,
  output logic                   result_valid,
  input  logic                   result_stall,
  output lcmd_pkg::result_t      result
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res.valid) begin
      result <= res.data;
    end
  end

endmodule

@@ sv/length_checked_message_deframer.sv @@
// top level of the length checked message deframer
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+------------------------------
//   item     | item_valid    | item_stall    | item   (operation, rx_byte)
//   result   | result_valid  | result_stall  | result (kind, payload_byte)
//
// one transaction per cycle sustained unless result stalls; a result is loaded
// into the result register as its transaction leaves the input register
// per byte the parser does a compare, a length store or a 31 bit counter step
// rst is synchronous and clears the parser state, both valid flags
// a stalled result holds; the input register keeps one more transaction and
// item_stall rises only while both registers are occupied and result is stalled
module length_checked_message_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lcmd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output lcmd_pkg::result_t result
);

  // transaction waiting in the input register
  logic            held_valid;
  lcmd_pkg::item_t held_item;

  // the parser consumes the held transaction whenever the result register can load
  logic out_free;
  logic advance;

  lcmd_pkg::result_slot_t res;

  assign advance = held_valid && out_free;

  lcmd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // parser state advances only on a consumed transaction
  lcmd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (held_item),
    .res  (res)
  );

  lcmd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ sv/lcmd_checker.sv @@
// port level checker for the deframer and its bind
module lcmd_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input lcmd_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input lcmd_pkg::result_t result
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // only the three defined kinds appear
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind == lcmd_pkg::KIND_PAYLOAD ||
                      result.kind == lcmd_pkg::KIND_DONE ||
                      result.kind == lcmd_pkg::KIND_ERROR))
    else $error("illegal result kind");

  // done and error transactions carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != lcmd_pkg::KIND_PAYLOAD) |-> result.payload_byte == 8'd0)
    else $error("non-payload result with non-zero byte");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // no input stall while the result side is free
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (item_stall && item_valid) |-> (result_valid && result_stall))
    else $error("input stalled with result side free");

endmodule

bind length_checked_message_deframer lcmd_checker u_lcmd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

@@ tb/sv/length_checked_message_deframer_checker.sv @@
`timescale 1ns / 1ps
// checker that predicts and compares the results of the length checked message deframer
module length_checked_message_deframer_checker
  import lcmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      failures,
  output int      pending
);

  logic [2:0]  phase;
  logic [1:0]  field_idx;
  logic [31:0] frame_len;
  logic [30:0] remaining;
  logic        halted;
  result_t     expected_results[$];
  result_t     oldest;
  int          mismatches = 0;

  function automatic logic [7:0] byte_at(input logic [31:0] word, input logic [1:0] pos);
    return word[8*pos +: 8];
  endfunction

  function automatic void clear_parser();
    phase     = PH_OPEN;
    field_idx = 2'd0;
    frame_len = 32'd0;
    remaining = 31'd0;
    halted    = 1'b0;
  endfunction

  function automatic void flag_error();
    halted = 1'b1;
    expected_results.push_back('{kind: KIND_ERROR, payload_byte: 8'h00});
  endfunction

  // true once the last byte of a matching four byte field has gone by
  function automatic bit field_matched(input logic [7:0] b, input logic [31:0] want);
    if (b != byte_at(want, field_idx)) begin
      flag_error();
      return 1'b0;
    end
    field_idx++;
    return field_idx == 2'd0;
  endfunction

  function automatic void deframe_transaction(input item_t it);
    logic [7:0] b;
    b = it.rx_byte;
    if (it.operation == OP_RESTART) begin
      clear_parser();
    end else if (!halted) begin
      case (phase)
        PH_OPEN: if (field_matched(b, MARK_OPEN)) phase = PH_LEN;
        PH_LEN: begin
          frame_len[8*field_idx +: 8] = b;
          field_idx++;
          if (field_idx == 2'd0) begin
            if (frame_len[31]) begin
              flag_error();
            end else begin
              remaining = frame_len[30:0];
              phase     = PH_HMARK;
            end
          end
        end
        PH_HMARK: if (field_matched(b, MARK_HDR)) begin
          phase = (remaining == 31'd0) ? PH_TMARK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          remaining--;
          if (remaining == 31'd0) phase = PH_TMARK;
          expected_results.push_back('{kind: KIND_PAYLOAD, payload_byte: b});
        end
        PH_TMARK: if (field_matched(b, MARK_TRL)) phase = PH_LEN2;
        PH_LEN2: if (field_matched(b, frame_len)) phase = PH_CLOSE;
        PH_CLOSE: if (field_matched(b, MARK_CLOSE)) begin
          phase     = PH_OPEN;
          frame_len = 32'd0;
          remaining = 31'd0;
          expected_results.push_back('{kind: KIND_DONE, payload_byte: 8'h00});
        end
        default: flag_error();
      endcase
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual kind %0d byte %02h",
                   $time, result.kind, result.payload_byte);
        end else begin
          oldest = expected_results.pop_front();
          if (result.kind !== oldest.kind) begin
            mismatches++;
            $display("%0t: kind mismatch, expected %0d, actual %0d",
                     $time, oldest.kind, result.kind);
          end
          if (result.payload_byte !== oldest.payload_byte) begin
            mismatches++;
            $display("%0t: payload_byte mismatch, expected %02h, actual %02h",
                     $time, oldest.payload_byte, result.payload_byte);
          end
        end
      end
      if (item_valid && !item_stall) deframe_transaction(item);
    end
    pending  <= expected_results.size();
    failures <= mismatches;
  end

endmodule

@@ tb/sv/length_checked_message_deframer_test.sv @@
`timescale 1ns / 1ps
// top of the length checked message deframer testbench: stimulus, stalls and verdict
module length_checked_message_deframer_test;
  import lcmd_pkg::*;

  // stimulus shaping
  localparam int ITEM_TARGET     = 1750;
  localparam int QUIET_FROM      = 1550;  // no idling on either side from here on
  localparam int HOLD_OFF_AT     = 400;   // receiver holds off once this count is reached
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_AT        = 800;   // sender pauses once until all results are back
  localparam int WATCHDOG_LIMIT  = 1000;

  // what kind of byte sequence the sender produces next
  typedef enum {
    FRAME_GOOD,
    FRAME_BAD_OPEN,
    FRAME_NEG_LEN,
    FRAME_BAD_HDR,
    FRAME_BAD_TRL,
    FRAME_BAD_LEN2,
    FRAME_BAD_CLOSE,
    FRAME_CUT_SHORT,
    LINE_NOISE
  } frame_shape_e;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  item_t   item         = '0;
  logic    result_stall = 1'b0;
  logic    item_stall;
  logic    result_valid;
  result_t result;
  int      failures;
  int      pending;

  int items_sent    = 0;   // counts every accepted input transaction
  bit quiet         = 1'b0;
  bit sender_idles  = 1'b1;
  int silent_cycles = 0;

  always #2 clk = ~clk;

  length_checked_message_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  length_checked_message_deframer_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .failures     (failures),
    .pending      (pending)
  );

  // offer one transaction, with an optional idle burst first, and hold it until taken;
  // valid stays high afterwards so a following call can present the next one at once
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    if (!quiet && sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{operation: op, rx_byte: b};
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (items_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  // restart transactions carry a random byte, the parser must ignore it
  task automatic send_restart();
    send_item(OP_RESTART, 8'($urandom));
  endtask

  function automatic void append_word(ref logic [7:0] bytes[$], input logic [31:0] word);
    for (int i = 0; i < 4; i++) bytes.push_back(word[8*i +: 8]);
  endfunction

  // build one frame, spoil at most one byte of it according to its shape and send it;
  // bytes after a spoilt one are still sent and the block drops them
  task automatic send_frame(input frame_shape_e shape, input logic [31:0] len);
    logic [7:0] bytes[$];
    int         n_pay;
    int         at;
    n_pay = (shape == FRAME_CUT_SHORT) ? $urandom_range(0, 6) : int'(len);
    append_word(bytes, MARK_OPEN);
    append_word(bytes, len);
    if (shape != FRAME_NEG_LEN) begin
      append_word(bytes, MARK_HDR);
      repeat (n_pay) bytes.push_back(8'($urandom));
      if (shape != FRAME_CUT_SHORT) begin
        append_word(bytes, MARK_TRL);
        append_word(bytes, len);
        append_word(bytes, MARK_CLOSE);
      end
    end
    case (shape)
      FRAME_BAD_OPEN:  at = $urandom_range(0, 3);
      FRAME_BAD_HDR:   at = 8 + $urandom_range(0, 3);
      FRAME_BAD_TRL:   at = 12 + n_pay + $urandom_range(0, 3);
      FRAME_BAD_LEN2:  at = 16 + n_pay + $urandom_range(0, 3);
      FRAME_BAD_CLOSE: at = 20 + n_pay + $urandom_range(0, 3);
      default:         at = -1;
    endcase
    if (at >= 0) bytes[at] = bytes[at] ^ 8'($urandom_range(1, 255));
    foreach (bytes[i]) send_item(OP_BYTE, bytes[i]);
  endtask

  // mostly short payloads, now and then a longer one
  function automatic logic [31:0] pick_length();
    if ($urandom_range(0, 9) == 0) return 32'($urandom_range(13, 100));
    return 32'($urandom_range(0, 12));
  endfunction

  // sender
  initial begin
    frame_shape_e shape;
    logic [31:0]  len;
    int           pick;
    bit           drained;
    drained = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: an empty frame straight after reset, then a restart while idle
    send_frame(FRAME_GOOD, 32'd0);
    send_restart();

    while (items_sent < ITEM_TARGET) begin
      // drop valid and wait for every outstanding result once
      if (!drained && items_sent >= DRAIN_AT) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        drained = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) sender_idles = !sender_idles;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(FRAME_GOOD, pick_length());
      end else if (pick < 60) begin
        send_restart();
      end else begin
        shape = frame_shape_e'($urandom_range(1, 8));
        case (shape)
          FRAME_NEG_LEN: begin
            case ($urandom_range(0, 2))
              0:       len = 32'h8000_0000;
              1:       len = 32'hFFFF_FFFF;
              default: len = {1'b1, 31'($urandom)};
            endcase
            send_frame(shape, len);
          end
          FRAME_CUT_SHORT: begin
            // huge length, header accepted, a few payload bytes, then the connection drops
            len = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : {2'b01, 30'($urandom)};
            send_frame(shape, len);
          end
          LINE_NOISE: begin
            for (int i = $urandom_range(1, 6); i > 0; i--) begin
              send_item(OP_BYTE, 8'($urandom));
            end
          end
          default: send_frame(shape, pick_length());
        endcase
        // bytes arriving after a fault are dropped until the restart; after a cut-short frame they are taken as payload
        repeat ($urandom_range(0, 4)) send_item(OP_BYTE, 8'($urandom));
        send_restart();
      end
    end

    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // the last transactions may give no result, let them clear the pipeline
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: short random stall bursts, one long hold-off so the block backs up
  initial begin
    bit held_off;
    int span;
    held_off = 1'b0;
    forever begin
      if (!held_off && items_sent >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        span = $urandom_range(1, 4);
        result_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // watchdog: ends the run when no transaction moves on either channel for too long
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      silent_cycles <= 0;
    end else if (silent_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

endmodule
